FILE: rtl/cfsd_pkg.sv
// Shared types and constants for the cartridge save flash device.
// Used by cfsd_cmd, cfsd_sweep, cfsd_store and cart_flash_save_device.
`timescale 1ns / 1ps
`default_nettype none

package cfsd_pkg;

    // Store geometry (powers of two)
    localparam int BANK_BYTES   = 65536;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_BYTES   = 128;
    localparam int STORE_BYTES  = 2 * BANK_BYTES;

    localparam int BANK_W = $clog2(BANK_BYTES);
    localparam int SECT_W = $clog2(SECTOR_BYTES);
    localparam int IDX_W  = $clog2(STORE_BYTES);
    localparam int PAGE_W = 8;

    // Bus constants
    localparam logic [15:0] ADDR_CMD    = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK = 16'h2AAA;
    localparam logic [7:0]  DATA_UNLOCK1 = 8'hAA;
    localparam logic [7:0]  DATA_UNLOCK2 = 8'h55;
    localparam logic [7:0]  CMD_ID_ENTRY = 8'h90;
    localparam logic [7:0]  CMD_ID_EXIT  = 8'hF0;
    localparam logic [7:0]  CMD_PROGRAM  = 8'hA0;
    localparam logic [7:0]  CMD_ERASE    = 8'h80;
    localparam logic [7:0]  CMD_SECTOR   = 8'h30;
    localparam logic [7:0]  CMD_BANK     = 8'hB0;
    localparam logic [7:0]  ERASED_BYTE  = 8'hFF;

    // Configuration register indexes
    localparam logic [1:0] REG_MAKER_CODE = 2'd0;
    localparam logic [1:0] REG_PART_CODE  = 2'd1;
    localparam logic [1:0] REG_PAGE_MODE  = 2'd2;
    localparam logic [1:0] REG_TWO_BANKS  = 2'd3;

    localparam logic [7:0] MAKER_CODE_RST = 8'hBF;
    localparam logic [7:0] PART_CODE_RST  = 8'h00;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ID     = 3'd1,
        MODE_PROG   = 3'd2,
        MODE_ERASE  = 3'd3,
        MODE_BANK   = 3'd4,
        MODE_PAGE   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        UNLOCK_IDLE = 2'd0,
        UNLOCK_AA   = 2'd1,
        UNLOCK_55   = 2'd2
    } unlock_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_EXEC  = 3'd2,
        ST_ERASE = 3'd3,
        ST_RESP  = 3'd4
    } state_t;

    // Store actions requested by the command tracker
    typedef struct packed {
        logic prog;
        logic erase;
    } cmd_act_t;

endpackage

`default_nettype wire

FILE: rtl/cfsd_store.sv
// Byte store of both banks: one write port, one read port, registered read.
// Depends on cfsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfsd_store
    import cfsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [7:0]       wdata,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    output logic      [7:0]       rdata
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/cfsd_sweep.sv
// Address sweep unit: walks a run of store bytes, one per cycle.
// Serves the clearing pass after reset and every sector erase. Depends on cfsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfsd_sweep
    import cfsd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [IDX_W-1:0] base,
    input  wire logic [IDX_W-1:0] len_m1,
    output logic                  busy,
    output logic                  last,
    output logic      [IDX_W-1:0] addr
);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] left_reg, left_next;

    // Out of reset the unit already runs the clearing pass over the whole store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
            left_reg <= IDX_W'(STORE_BYTES - 1);
        end
        else
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
            left_reg <= left_next;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        if (start)
        begin
            busy_next = 1'b1;
            addr_next = base;
            left_next = len_m1;
        end
        else if (busy_reg)
        begin
            addr_next = addr_reg + 1'b1;
            left_next = left_reg - 1'b1;
            if (left_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign last = busy_reg && (left_reg == '0);
    assign addr = addr_reg;

endmodule

`default_nettype wire

FILE: rtl/cfsd_cmd.sv
// Command tracker: unlock sequence, command mode, bank bit, page counter.
// Steps once per bus write; depends on cfsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfsd_cmd
    import cfsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [15:0] address,
    input  wire logic [7:0]  write_data,
    input  wire logic        page_mode,
    input  wire logic        two_banks,
    output mode_t            mode,
    output logic             bank,
    output cmd_act_t         act
);

    unlock_t           unlock_reg, unlock_next;
    mode_t             mode_reg, mode_next;
    logic              bank_reg, bank_next;
    logic [PAGE_W-1:0] left_reg, left_next;
    logic              at_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unlock_reg <= UNLOCK_IDLE;
            mode_reg   <= MODE_NORMAL;
            bank_reg   <= 1'b0;
            left_reg   <= '0;
        end
        else
        begin
            unlock_reg <= unlock_next;
            mode_reg   <= mode_next;
            bank_reg   <= bank_next;
            left_reg   <= left_next;
        end
    end

    assign at_cmd = (address == ADDR_CMD);

    always_comb
    begin
        unlock_next = unlock_reg;
        mode_next   = mode_reg;
        bank_next   = bank_reg;
        left_next   = left_reg;
        act         = '0;
        if (step)
        begin
            if (mode_reg == MODE_PROG)
            begin
                act.prog    = 1'b1;
                mode_next   = MODE_NORMAL;
                unlock_next = UNLOCK_IDLE;
            end
            else if (mode_reg == MODE_PAGE)
            begin
                act.prog = 1'b1;
                if (left_reg == '0)
                begin
                    mode_next = MODE_NORMAL;
                end
                else
                begin
                    left_next = left_reg - 1'b1;
                end
                unlock_next = UNLOCK_IDLE;
            end
            else if (mode_reg == MODE_BANK)
            begin
                if (address == '0)
                begin
                    bank_next = write_data[0];
                end
                mode_next   = MODE_NORMAL;
                unlock_next = UNLOCK_IDLE;
            end
            else
            begin
                case (unlock_reg)
                    UNLOCK_IDLE:
                    begin
                        if (at_cmd && write_data == DATA_UNLOCK1)
                        begin
                            unlock_next = UNLOCK_AA;
                        end
                        else if (write_data == CMD_ID_EXIT &&
                                 (mode_reg == MODE_ID || mode_reg == MODE_ERASE))
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    UNLOCK_AA:
                    begin
                        unlock_next = (address == ADDR_UNLOCK && write_data == DATA_UNLOCK2)
                                      ? UNLOCK_55 : UNLOCK_IDLE;
                    end
                    default:
                    begin
                        unlock_next = UNLOCK_IDLE;
                        // An armed erase is consumed by this unlock either way
                        if (mode_reg == MODE_ERASE)
                        begin
                            mode_next = MODE_NORMAL;
                            if (write_data == CMD_SECTOR)
                            begin
                                act.erase = 1'b1;
                            end
                        end
                        if (!act.erase && at_cmd)
                        begin
                            case (write_data)
                                CMD_ID_ENTRY: mode_next = MODE_ID;
                                CMD_ID_EXIT:  mode_next = MODE_NORMAL;
                                CMD_PROGRAM:
                                begin
                                    if (page_mode)
                                    begin
                                        mode_next = MODE_PAGE;
                                        left_next = PAGE_W'(PAGE_BYTES - 1);
                                    end
                                    else
                                    begin
                                        mode_next = MODE_PROG;
                                    end
                                end
                                CMD_ERASE:
                                begin
                                    if (!page_mode)
                                    begin
                                        mode_next = MODE_ERASE;
                                    end
                                end
                                CMD_BANK:
                                begin
                                    if (two_banks)
                                    begin
                                        mode_next = MODE_BANK;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    assign mode = mode_reg;
    assign bank = bank_reg & two_banks;

endmodule

`default_nettype wire

FILE: rtl/cart_flash_save_device.sv
// Cartridge save flash device, two 64K banks with a JEDEC-style command set.
// Items pass through ST_EXEC, ST_ERASE for a sector erase, and ST_RESP; one at a time.
// A sector erase sweeps its 4096-byte sector; the sweep unit writes one byte per cycle.
// Reset: asynchronous, active low. After reset the sweep unit fills all 131072
// bytes with 0xFF, one per cycle; s_tready stays low for those cycles.
// Configuration writes are taken at any time, including during that fill.
`timescale 1ns / 1ps
`default_nettype none

module cart_flash_save_device
    import cfsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    // Bus access in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  wire logic        s_tuser,   // req_type: 0 read, 1 write

    // Access result out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] read_data
    output logic             m_tuser    // id_active
);

    // Configuration registers
    logic [7:0] maker_code_reg;
    logic [7:0] part_code_reg;
    logic       page_mode_reg;
    logic       two_banks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maker_code_reg <= MAKER_CODE_RST;
            part_code_reg  <= PART_CODE_RST;
            page_mode_reg  <= 1'b0;
            two_banks_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAKER_CODE: maker_code_reg <= cfg_data;
                REG_PART_CODE:  part_code_reg  <= cfg_data;
                REG_PAGE_MODE:  page_mode_reg  <= cfg_data[0];
                REG_TWO_BANKS:  two_banks_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer state and captured item
    state_t      state_reg, state_next;
    logic        req_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic        accept;

    // Output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_data_reg,  m_data_next;
    logic       m_user_reg,  m_user_next;

    // Submodule wiring
    mode_t            mode;
    logic             bank;
    cmd_act_t         act;
    logic             cmd_step;
    logic             sw_start;
    logic [IDX_W-1:0] sw_base;
    logic             sw_busy;
    logic             sw_last;
    logic [IDX_W-1:0] sw_addr;
    logic             st_we;
    logic [IDX_W-1:0] st_waddr;
    logic [7:0]       st_wdata;
    logic             st_re;
    logic [IDX_W-1:0] bus_idx;
    logic [7:0]       st_rdata;
    logic [7:0]       rd_byte;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Hold the item while it is worked on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= s_tuser;
            addr_reg  <= s_tdata[15:0];
            wdata_reg <= s_tdata[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Store index of the current access: effective bank above the in-bank offset
    assign bus_idx = {bank, addr_reg[BANK_W-1:0]};

    // Sector base: drop the in-sector offset bits
    assign sw_base = {bank, addr_reg[BANK_W-1:SECT_W], {SECT_W{1'b0}}};

    assign cmd_step = (state_reg == ST_EXEC) && req_reg;
    assign sw_start = cmd_step && act.erase;

    // The sweep owns the write port while it runs; otherwise a program write uses it
    always_comb
    begin
        if (sw_busy)
        begin
            st_we    = 1'b1;
            st_waddr = sw_addr;
            st_wdata = ERASED_BYTE;
        end
        else
        begin
            st_we    = cmd_step && act.prog;
            st_waddr = bus_idx;
            st_wdata = wdata_reg;
        end
    end

    assign st_re = (state_reg == ST_EXEC) && !req_reg;

    // Reads never change the mode, so the ID offsets can be decoded in the response cycle
    always_comb
    begin
        if (req_reg)
        begin
            rd_byte = 8'h00;
        end
        else if (mode == MODE_ID && addr_reg == 16'h0000)
        begin
            rd_byte = maker_code_reg;
        end
        else if (mode == MODE_ID && addr_reg == 16'h0001)
        begin
            rd_byte = part_code_reg;
        end
        else
        begin
            rd_byte = st_rdata;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sw_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sw_start ? ST_ERASE : ST_RESP;
            end
            ST_ERASE:
            begin
                if (sw_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                // Load the output register once the previous result is gone
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_byte;
                    m_user_next  = (mode == MODE_ID);
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    cfsd_cmd u_cmd (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (cmd_step),
        .address    (addr_reg),
        .write_data (wdata_reg),
        .page_mode  (page_mode_reg),
        .two_banks  (two_banks_reg),
        .mode       (mode),
        .bank       (bank),
        .act        (act)
    );

    cfsd_sweep u_sweep (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sw_start),
        .base   (sw_base),
        .len_m1 (IDX_W'(SECTOR_BYTES - 1)),
        .busy   (sw_busy),
        .last   (sw_last),
        .addr   (sw_addr)
    );

    cfsd_store u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (bus_idx),
        .rdata (st_rdata)
    );

endmodule

`default_nettype wire

FILE: sim/tb_cart_flash_save_device.sv
// Testbench for cart_flash_save_device: drives bus accesses, predicts each reply
// with a behavioral flash model kept here, and checks every reply field by field.
// Depends on cfsd_pkg (codes, geometry) and the cart_flash_save_device RTL.
`timescale 1ns / 1ps

module tb_cart_flash_save_device;
    import cfsd_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 7;
    // Budget for the clear pass, the sector erases and ~800 items with gaps and stalls,
    // taken several times over.
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] read_data;
        logic       id_active;
    } flash_reply_t;

    // DUT ports, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_MAKER_CODE;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = 24'h0;   // [15:0] address, [23:16] write_data
    logic        s_tuser   = 1'b0;    // req_type: 0 read, 1 write
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;             // [7:0] read_data
    logic        m_tuser;             // id_active

    cart_flash_save_device u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Flash model: configuration, command tracker and byte store
    // ------------------------------------------------------------------
    logic [7:0] cfg_maker;
    logic [7:0] cfg_part;
    logic       cfg_page_mode;
    logic       cfg_two_banks;

    unlock_t    unlock_seen;
    mode_t      cur_mode;
    logic       bank_sel;
    logic [7:0] page_left;
    logic [7:0] flash_mem [STORE_BYTES];

    // Replies predicted for accepted items, oldest first
    flash_reply_t pending_replies[$];

    int   fail_count   = 0;
    int   cycle_count  = 0;
    int   items_sent   = 0;
    int   erase_budget = 36;   // each sector erase makes the RTL sweep a whole sector
    int   hold_left    = 0;    // receiver hold-off, counted by the receiver process
    bit   steady       = 1'b0; // 1: neither side idles
    logic [15:0] addr_pool [16];

    function automatic void reset_flash_model();
        cfg_maker     = MAKER_CODE_RST;
        cfg_part      = PART_CODE_RST;
        cfg_page_mode = 1'b0;
        cfg_two_banks = 1'b1;
        unlock_seen   = UNLOCK_IDLE;
        cur_mode      = MODE_NORMAL;
        bank_sel      = 1'b0;
        page_left     = 8'h00;
        for (int i = 0; i < STORE_BYTES; i++)
            flash_mem[i] = ERASED_BYTE;
    endfunction

    // Bank in use is the select bit gated by the two-bank setting
    function automatic int unsigned mem_index(logic [15:0] a);
        int unsigned base;
        base = (bank_sel & cfg_two_banks) ? BANK_BYTES : 0;
        return base + int'(a);
    endfunction

    function automatic void wipe_sector(logic [15:0] a);
        int unsigned base;
        int unsigned first;
        base  = mem_index(16'h0000);
        first = int'(a) - (int'(a) % SECTOR_BYTES);
        // clip at the bank end
        for (int unsigned i = 0; i < SECTOR_BYTES && first + i < BANK_BYTES; i++)
            flash_mem[base + first + i] = ERASED_BYTE;
    endfunction

    function automatic void decode_cmd(logic [15:0] a, logic [7:0] d);
        if (cur_mode == MODE_ERASE)
        begin
            // an armed erase is used up by this unlock either way
            cur_mode = MODE_NORMAL;
            if (d == CMD_SECTOR)
            begin
                wipe_sector(a);
                return;
            end
        end
        if (a != ADDR_CMD)
            return;
        case (d)
            CMD_ID_ENTRY: cur_mode = MODE_ID;
            CMD_ID_EXIT:  cur_mode = MODE_NORMAL;
            CMD_PROGRAM:
            begin
                if (cfg_page_mode)
                begin
                    cur_mode  = MODE_PAGE;
                    page_left = 8'(PAGE_BYTES - 1);
                end
                else
                    cur_mode = MODE_PROG;
            end
            CMD_ERASE: if (!cfg_page_mode) cur_mode = MODE_ERASE;
            CMD_BANK:  if (cfg_two_banks) cur_mode = MODE_BANK;
            default: ;
        endcase
    endfunction

    function automatic void apply_write(logic [15:0] a, logic [7:0] d);
        case (cur_mode)
            MODE_PROG:
            begin
                flash_mem[mem_index(a)] = d;
                cur_mode    = MODE_NORMAL;
                unlock_seen = UNLOCK_IDLE;
            end
            MODE_PAGE:
            begin
                flash_mem[mem_index(a)] = d;
                if (page_left == 8'h00)
                    cur_mode = MODE_NORMAL;
                else
                    page_left = page_left - 8'd1;
                unlock_seen = UNLOCK_IDLE;
            end
            MODE_BANK:
            begin
                if (a == 16'h0000)
                    bank_sel = d[0];
                cur_mode    = MODE_NORMAL;
                unlock_seen = UNLOCK_IDLE;
            end
            default:
            begin
                case (unlock_seen)
                    UNLOCK_IDLE:
                    begin
                        if (a == ADDR_CMD && d == DATA_UNLOCK1)
                            unlock_seen = UNLOCK_AA;
                        else if (d == CMD_ID_EXIT &&
                                 (cur_mode == MODE_ID || cur_mode == MODE_ERASE))
                            cur_mode = MODE_NORMAL;   // single-write exit
                    end
                    UNLOCK_AA:
                        unlock_seen = (a == ADDR_UNLOCK && d == DATA_UNLOCK2) ?
                                      UNLOCK_55 : UNLOCK_IDLE;
                    default:
                    begin
                        unlock_seen = UNLOCK_IDLE;
                        decode_cmd(a, d);
                    end
                endcase
            end
        endcase
    endfunction

    function automatic flash_reply_t predict_access(bit wr, logic [15:0] a, logic [7:0] d);
        flash_reply_t r;
        r.read_data = 8'h00;
        if (wr)
            apply_write(a, d);
        else if (cur_mode == MODE_ID && a == 16'h0000)
            r.read_data = cfg_maker;
        else if (cur_mode == MODE_ID && a == 16'h0001)
            r.read_data = cfg_part;
        else
            r.read_data = flash_mem[mem_index(a)];
        r.id_active = (cur_mode == MODE_ID);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        forever
            #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("cart_flash_save_device verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 35);
    end

    // Compare each delivered reply with the oldest prediction
    always @(posedge clk)
    begin : reply_check
        flash_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: read_data %02h id_active %0b", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_tdata !== want.read_data)
                begin
                    $error("read_data: expected %02h, got %02h", want.read_data, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.id_active)
                begin
                    $error("id_active: expected %0b, got %0b", want.id_active, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one access; predict its reply at the edge that accepts it.
    // Valid stays high into the next item when no gap is drawn.
    task automatic send_access(input bit wr, input logic [15:0] a, input logic [7:0] d);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 35) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wr;
        s_tdata  <= {d, a};
        do
            @(posedge clk);
        while (!s_tready);
        pending_replies.push_back(predict_access(wr, a, d));
        items_sent++;
    endtask

    task automatic unlock_cmd(input logic [7:0] cmd, input logic [15:0] at);
        send_access(1'b1, ADDR_CMD, DATA_UNLOCK1);
        send_access(1'b1, ADDR_UNLOCK, DATA_UNLOCK2);
        send_access(1'b1, at, cmd);
    endtask

    // Drop valid, wait out every reply, then let the pipeline settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_MAKER_CODE: cfg_maker     = val;
            REG_PART_CODE:  cfg_part      = val;
            REG_PAGE_MODE:  cfg_page_mode = val[0];
            REG_TWO_BANKS:  cfg_two_banks = val[0];
            default: ;
        endcase
    endtask

    // Write all four registers; flag registers get junk in their unused bits
    task automatic load_settings(input logic [7:0] maker, input logic [7:0] part,
                                 input bit page, input bit banks);
        write_reg(REG_MAKER_CODE, maker);
        write_reg(REG_PART_CODE, part);
        write_reg(REG_PAGE_MODE, {7'($urandom), page});
        write_reg(REG_TWO_BANKS, {7'($urandom), banks});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] any_addr();
        return 16'($urandom);
    endfunction

    // Mostly reuse a small set of addresses so reads hit programmed bytes
    function automatic logic [15:0] pool_addr();
        if ($urandom_range(0, 3) == 0)
            return any_addr();
        return addr_pool[$urandom_range(0, 15)];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every command, and the corner cases of the tracker
    task automatic test_directed();
        send_access(1'b0, 16'hFFFF, 8'hFF);               // erased byte
        unlock_cmd(CMD_PROGRAM, ADDR_CMD);
        send_access(1'b1, 16'h0000, 8'h00);               // program lowest address
        unlock_cmd(CMD_PROGRAM, ADDR_CMD);
        send_access(1'b1, 16'hFFFF, 8'h5A);               // program highest address
        send_access(1'b0, 16'h0000, 8'h00);
        unlock_cmd(CMD_ID_ENTRY, ADDR_CMD);
        send_access(1'b0, 16'h0000, 8'h00);               // maker code
        send_access(1'b0, 16'h0001, 8'h00);               // part code
        send_access(1'b0, 16'hFFFF, 8'h00);               // store read while in ID mode
        send_access(1'b1, 16'h1234, CMD_ID_EXIT);         // single-write exit
        unlock_cmd(CMD_ERASE, ADDR_CMD);
        unlock_cmd(CMD_SECTOR, 16'h0FFF);                 // erase sector holding address 0
        send_access(1'b0, 16'h0000, 8'h00);
        unlock_cmd(CMD_BANK, ADDR_CMD);
        send_access(1'b1, 16'h0000, 8'hFF);               // select upper bank
        send_access(1'b0, 16'hFFFF, 8'h00);               // upper bank still erased
        send_access(1'b1, ADDR_CMD, DATA_UNLOCK1);
        send_access(1'b1, ADDR_UNLOCK, 8'h00);            // broken unlock
    endtask

    // Random command traffic: mostly complete sequences, some noise and
    // broken sequences; stops after n accepted items
    task automatic test_command_mix(input int n);
        int first;
        int kind;
        int count;
        logic [15:0] a;
        first = items_sent;
        while (items_sent - first < n)
        begin
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1:
                    send_access(1'($urandom_range(0, 1)), any_addr(), 8'($urandom));
                2:
                    send_access(1'b0, pool_addr(), 8'($urandom));
                3:
                begin
                    unlock_cmd(CMD_ID_ENTRY, ADDR_CMD);
                    repeat ($urandom_range(1, 4))
                        send_access(1'b0, 16'($urandom_range(0, 2)), 8'($urandom));
                    send_access(1'b0, pool_addr(), 8'($urandom));
                    if ($urandom_range(0, 1) == 1)
                        send_access(1'b1, any_addr(), CMD_ID_EXIT);
                    else
                        unlock_cmd(CMD_ID_EXIT, ADDR_CMD);
                end
                4, 5:
                begin
                    a = pool_addr();
                    unlock_cmd(CMD_PROGRAM, ADDR_CMD);
                    if (cfg_page_mode)
                    begin
                        // mostly short bursts; a full page now and then
                        count = ($urandom_range(0, 5) == 0) ? PAGE_BYTES : $urandom_range(1, 8);
                        repeat (count)
                            send_access(1'b1, pool_addr(), 8'($urandom));
                    end
                    else
                        send_access(1'b1, a, 8'($urandom));
                    send_access(1'b0, a, 8'($urandom));
                end
                6:
                begin
                    if (erase_budget > 0)
                    begin
                        erase_budget--;
                        a = pool_addr();
                        unlock_cmd(CMD_ERASE, ADDR_CMD);
                        unlock_cmd(CMD_SECTOR, a);
                        send_access(1'b0, a, 8'($urandom));
                    end
                end
                7:
                begin
                    unlock_cmd(CMD_BANK, ADDR_CMD);
                    a = ($urandom_range(0, 3) == 0) ? any_addr() : 16'h0000;
                    send_access(1'b1, a, 8'($urandom));
                end
                8:
                begin
                    send_access(1'b1, ADDR_CMD, DATA_UNLOCK1);
                    send_access(1'b1, ($urandom_range(0, 1) == 1) ? ADDR_UNLOCK : any_addr(),
                                ($urandom_range(0, 1) == 1) ? DATA_UNLOCK2 : 8'($urandom));
                end
                9:
                    // unknown command, or a command away from the command address
                    unlock_cmd(8'($urandom), ($urandom_range(0, 1) == 1) ? ADDR_CMD : any_addr());
                10:
                begin
                    // arm an erase, then cancel it
                    unlock_cmd(CMD_ERASE, ADDR_CMD);
                    if ($urandom_range(0, 1) == 1)
                        send_access(1'b1, any_addr(), CMD_ID_EXIT);
                    else
                        unlock_cmd(($urandom_range(0, 1) == 1) ? CMD_ID_ENTRY : CMD_BANK,
                                   ADDR_CMD);
                end
                default:
                    // read the ID offsets; outside ID mode they come from the store
                    send_access(1'b0, 16'($urandom_range(0, 1)), 8'($urandom));
            endcase
        end
    endtask

    // Stall the receiver for a long stretch while items keep coming, so the
    // block backs up and drops s_tready
    task automatic test_backpressure();
        steady    = 1'b1;
        hold_left = HOLD_CYCLES;
        repeat (24)
            send_access(1'($urandom_range(0, 1)), pool_addr(), 8'($urandom));
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        addr_pool[0] = 16'h0000;
        addr_pool[1] = 16'h0001;
        addr_pool[2] = 16'hFFFF;
        addr_pool[3] = ADDR_CMD;
        addr_pool[4] = ADDR_UNLOCK;
        addr_pool[5] = 16'h0FFF;
        addr_pool[6] = 16'h1000;
        addr_pool[7] = 16'hF000;
        for (int i = 8; i < 16; i++)
            addr_pool[i] = 16'($urandom);
        reset_flash_model();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extreme ID codes, byte program, both banks
        load_settings(8'h00, 8'hFF, 1'b0, 1'b1);
        test_directed();
        steady = 1'b1;          // opening stretch with no idling on either side
        test_command_mix(80);
        steady = 1'b0;
        test_command_mix(170);
        wait_drain();

        // page program, opposite code extremes
        load_settings(8'hFF, 8'h00, 1'b1, 1'b1);
        test_command_mix(200);
        wait_drain();

        // single bank: bank select ignored, bank bit gated off
        load_settings(MAKER_CODE_RST, 8'h1F, 1'b0, 1'b0);
        test_command_mix(200);
        wait_drain();

        load_settings(8'($urandom), 8'($urandom), 1'b0, 1'b1);
        test_backpressure();
        test_command_mix(100);
        wait_drain();

        if (fail_count == 0)
            $display("cart_flash_save_device verification clean");
        else
            $display("cart_flash_save_device verification failed");
        $finish;
    end

endmodule

FILE: cart_flash_save_device.f
rtl/cfsd_pkg.sv
rtl/cfsd_store.sv
rtl/cfsd_sweep.sv
rtl/cfsd_cmd.sv
rtl/cart_flash_save_device.sv
sim/tb_cart_flash_save_device.sv
